// ===== rtl/aes_pkg.sv =====
package aes_pkg;

    localparam int MaxWords = 60;
    localparam int WordIdxW = 6;
    localparam int RegIdxW  = 3;

    localparam logic [RegIdxW-1:0] RegMode  = 3'd0;
    localparam logic [RegIdxW-1:0] RegKey0  = 3'd1;
    localparam logic [RegIdxW-1:0] RegKey1  = 3'd2;
    localparam logic [RegIdxW-1:0] RegKey2  = 3'd3;
    localparam logic [RegIdxW-1:0] RegKey3  = 3'd4;

    localparam logic OpEncrypt = 1'b0;
    localparam logic OpDecrypt = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXP,
        ST_LOAD,
        ST_ROUND,
        ST_DONE
    } aes_state_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3;
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
    endfunction

    function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3, u, v;
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        // 0e/0b/0d/09 = 02/03/01/01 after a pre-step
        u = xtime(xtime(a0 ^ a2));
        v = xtime(xtime(a1 ^ a3));
        return mix_col({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
    endfunction

endpackage

// ===== rtl/aes_block_cipher.sv =====
// iterative aes core, 128/192/256-bit keys. round keys live in a 60-word
// synchronous ram (one read a cycle). after reset or any key or mode
// register write the first block triggers key expansion, one word per
// cycle: 44, 52 or 60 words and a spare step so the last word is in the ram
// before the first key row is read. a block then passes a load step that
// adds round key 0 (or nr), one round per cycle, then the result register.
// each round reads its four key words, which are fetched as one 128-bit row
// from four word-wide rams in parallel. the next block is taken while the
// result word waits; a finished block holds in its last step until the
// result register is free.
module aes_block_cipher
    import aes_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [RegIdxW-1:0]  cfg_index,
    input  logic [63:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                opcode,
    input  logic [63:0]         block_high,
    input  logic [63:0]         block_low,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [63:0]         result_high,
    output logic [63:0]         result_low
);

    // four banks, entry r of bank c holds word 4r+c
    logic [31:0] rk_mem0 [15];
    logic [31:0] rk_mem1 [15];
    logic [31:0] rk_mem2 [15];
    logic [31:0] rk_mem3 [15];

    aes_state_t state_reg, state_next;
    logic [1:0]   mode_reg;
    logic [63:0]  key_reg [4];
    logic         expanded_reg;
    logic         op_reg;
    logic [127:0] st_reg;
    logic [3:0]   rnd_reg, rnd_next;
    logic [WordIdxW-1:0] wi_reg;
    logic [2:0]   kc_reg;
    logic [7:0]   rcon_reg;
    logic [255:0] win_reg;     // last eight words, newest in [31:0]
    logic         out_valid_reg;
    logic [127:0] out_reg;

    logic [3:0]   nk, nr;
    logic [WordIdxW-1:0] total;
    logic [3:0]   rd_row;
    logic [127:0] rk_row;
    logic [31:0]  w_prev, w_back, w_new, t;
    logic [31:0]  key_word, wdata;
    logic         done_fire;

    assign nk = (mode_reg == 2'd0) ? 4'd4 : (mode_reg == 2'd1) ? 4'd6 : 4'd8;
    assign nr = nk + 4'd6;
    assign total = WordIdxW'({nk, 2'b00} + 6'd28);

    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign result_high = out_reg[127:64];
    assign result_low  = out_reg[63:0];
    assign done_fire = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // raw key word wi, used while wi < nk
    assign key_word = wi_reg[0] ? key_reg[wi_reg[2:1]][31:0] : key_reg[wi_reg[2:1]][63:32];
    assign wdata    = (wi_reg < WordIdxW'(nk)) ? key_word : w_new;

    // expansion word
    always_comb
    begin
        w_prev = win_reg[31:0];
        case (nk)
            4'd4: w_back = win_reg[127:96];
            4'd6: w_back = win_reg[191:160];
            default: w_back = win_reg[255:224];
        endcase
        t = w_prev;
        if (kc_reg == 3'd0)
            t = sub_word({w_prev[23:0], w_prev[31:24]}) ^ {rcon_reg, 24'h0};
        else if (nk == 4'd8 && kc_reg == 3'd4)
            t = sub_word(w_prev);
        w_new = w_back ^ t;
    end

    // round row address: next round while running
    always_comb
    begin
        rd_row = rnd_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EXP && wi_reg != total)
        begin
            unique case (wi_reg[1:0])
                2'd0: rk_mem0[wi_reg[5:2]] <= wdata;
                2'd1: rk_mem1[wi_reg[5:2]] <= wdata;
                2'd2: rk_mem2[wi_reg[5:2]] <= wdata;
                default: rk_mem3[wi_reg[5:2]] <= wdata;
            endcase
        end
        rk_row <= {rk_mem0[rd_row], rk_mem1[rd_row], rk_mem2[rd_row], rk_mem3[rd_row]};
    end

    // round datapath
    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
        logic [7:0] b [16];
        logic [7:0] o [16];
        logic [127:0] r;
        for (int i = 0; i < 16; i++) b[i] = SBOX[s[127-8*i -: 8]];
        for (int c = 0; c < 4; c++)
            for (int rr = 0; rr < 4; rr++) o[4*c+rr] = b[rr + 4*((c+rr)%4)];
        for (int i = 0; i < 16; i++) r[127-8*i -: 8] = o[i];
        if (!last)
            for (int c = 0; c < 4; c++) r[127-32*c -: 32] = mix_col(r[127-32*c -: 32]);
        return r;
    endfunction

    function automatic logic [127:0] dec_round(input logic [127:0] s);
        logic [7:0] b [16];
        logic [127:0] r;
        for (int c = 0; c < 4; c++)
            for (int rr = 0; rr < 4; rr++) b[rr + 4*((c+rr)%4)] = s[127-8*(rr+4*c) -: 8];
        for (int i = 0; i < 16; i++) r[127-8*i -: 8] = INV_SBOX[b[i]];
        return r;
    endfunction

    function automatic logic [127:0] imix(input logic [127:0] s);
        logic [127:0] r;
        for (int c = 0; c < 4; c++) r[127-32*c -: 32] = inv_mix_col(s[127-32*c -: 32]);
        return r;
    endfunction

    logic [127:0] round_out;
    logic         last_round;
    assign last_round = (op_reg == OpDecrypt) ? (rnd_reg == 4'd0) : (rnd_reg == nr);
    always_comb
    begin
        if (op_reg == OpEncrypt)
            round_out = enc_round(st_reg, last_round) ^ rk_row;
        else if (last_round)
            round_out = dec_round(st_reg) ^ rk_row;
        else
            round_out = imix(dec_round(st_reg) ^ rk_row);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid && in_ready)
                    state_next = expanded_reg ? ST_LOAD : ST_EXP;
            // a spare step after the last word lets its write land
            ST_EXP:
                if (wi_reg == total) state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_ROUND;
            ST_ROUND: if (last_round) state_next = ST_DONE;
            ST_DONE:  if (done_fire) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // rnd_reg names the key row the current step uses
    always_comb
    begin
        rnd_next = rnd_reg;
        unique case (state_reg)
            ST_IDLE:  rnd_next = (opcode == OpDecrypt) ? nr : 4'd0;
            ST_EXP:   rnd_next = (op_reg == OpDecrypt) ? nr : 4'd0;
            ST_LOAD, ST_ROUND:
                rnd_next = (op_reg == OpDecrypt) ? rnd_reg - 4'd1 : rnd_reg + 4'd1;
            default:  rnd_next = rnd_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= 2'd0;
            key_reg       <= '{default: 64'h0};
            expanded_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rnd_reg       <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    RegMode:
                    begin
                        mode_reg     <= (cfg_data[1:0] == 2'd3) ? 2'd2 : cfg_data[1:0];
                        expanded_reg <= 1'b0;
                    end
                    RegKey0: begin key_reg[0] <= cfg_data; expanded_reg <= 1'b0; end
                    RegKey1: begin key_reg[1] <= cfg_data; expanded_reg <= 1'b0; end
                    RegKey2: begin key_reg[2] <= cfg_data; expanded_reg <= 1'b0; end
                    RegKey3: begin key_reg[3] <= cfg_data; expanded_reg <= 1'b0; end
                    default: ;
                endcase
            end
            if (state_reg == ST_EXP && state_next == ST_LOAD) expanded_reg <= 1'b1;
            if (done_fire) out_valid_reg <= 1'b1;
            else if (out_ready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid && in_ready)
        begin
            op_reg   <= opcode;
            st_reg   <= {block_high, block_low};
            wi_reg   <= '0;
            kc_reg   <= 3'd0;
            rcon_reg <= 8'h01;
            win_reg  <= '0;
        end
        else if (state_reg == ST_EXP)
        begin
            wi_reg  <= wi_reg + 1'b1;
            // kc_reg tracks wi mod nk
            kc_reg  <= (kc_reg == 3'(nk - 4'd1)) ? 3'd0 : kc_reg + 3'd1;
            win_reg <= {win_reg[223:0], wdata};
            if (wi_reg >= WordIdxW'(nk) && kc_reg == 3'd0)
                rcon_reg <= xtime(rcon_reg);
        end
        else if (state_reg == ST_LOAD)
            st_reg <= st_reg ^ rk_row;
        else if (state_reg == ST_ROUND)
            st_reg <= round_out;
        if (done_fire) out_reg <= st_reg;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_high) && $stable(result_low));

    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |-> state_reg == ST_IDLE);

    a_round_keys: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROUND |-> expanded_reg && rnd_reg <= nr);

    a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EXP |-> wi_reg <= total);

endmodule
